### hw/rtl/splr_pkg.sv
`default_nettype none

package splr_pkg;

	typedef enum logic [2:0] {
		PH_AWAIT_FF = 3'd0,
		PH_AWAIT_ID = 3'd1,
		PH_HEADER   = 3'd2,
		PH_SIZE     = 3'd3,
		PH_PAYLOAD  = 3'd4,
		PH_HALTED   = 3'd5
	} phase_t;

	// input operation codes
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_TX      = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	// packet status codes
	localparam logic [2:0] ST_ACCEPTED = 3'd0;
	localparam logic [2:0] ST_DUMMY    = 3'd1;
	localparam logic [2:0] ST_END      = 3'd2;
	localparam logic [2:0] ST_WRONG_ID = 3'd3;
	localparam logic [2:0] ST_OVERSIZE = 3'd4;
	localparam logic [2:0] ST_TIMEOUT  = 3'd5;
	localparam logic [2:0] ST_SYNC_ERR = 3'd6;

	localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
	localparam logic [7:0]  STUFF_BYTE = 8'h00;
	localparam logic [23:0] END_MARKER = 24'hFFFFFE;

	// configuration register word index
	localparam logic REG_STATION_ID = 1'b0;

	// result slots of one queued action, emitted lowest first
	localparam int NSLOT    = 9;
	localparam int SL_P0    = 0;
	localparam int SL_P1    = 1;
	localparam int SL_HALT  = 2;
	localparam int SL_FF    = 3;
	localparam int SL_ID    = 4;
	localparam int SL_LRC   = 5;
	localparam int SL_ESC0  = 6;
	localparam int SL_ACKST = 7;
	localparam int SL_MARK  = 8;

	typedef struct packed {
		logic       operation;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic [23:0] load_address;
		logic [2:0]  status;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [NSLOT-1:0] slots;
		logic [7:0]       p0_byte;
		logic [23:0]      p0_addr;
		logic [7:0]       p1_byte;
		logic [23:0]      p1_addr;
		logic [2:0]       halt_st;
		logic [7:0]       lrc;
		logic [7:0]       id;
		logic             first;
	} act_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

### hw/rtl/splr_front.sv
`default_nettype none

module splr_front #(
	parameter int MAX_PACKET_BYTES = 512
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire splr_pkg::in_t   in_data,
	input  wire logic [7:0]      station_id,
	input  wire splr_pkg::qstat_t qstat,
	output logic                 push,
	output splr_pkg::act_t       act,
	output logic                 halted
);

	localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
	localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_PACKET_BYTES);
	localparam logic [31:0]   SIZE_LIMIT = 32'(MAX_PACKET_BYTES);

	typedef struct packed {
		splr_pkg::phase_t phase;
		logic [1:0]       fidx;
		logic [31:0]      hdr;
		logic [31:0]      size;   // size word, then bytes still to come
		logic [CW-1:0]    cnt;    // bytes forwarded, saturates at max
		logic [23:0]      addr;
		logic [7:0]       lrc;
		logic             first;
		logic             over;
	} fst_t;

	typedef struct packed {
		fst_t        s;
		logic        pay_v;
		logic [7:0]  pay_byte;
		logic [23:0] pay_addr;
		logic        fin_v;
		logic        fin_halt;
		logic [2:0]  fin_st;
		logic [7:0]  fin_lrc;
		logic        fin_first;
		logic        fin_mk;
	} td_t;

	function automatic fst_t start_pkt(fst_t s);
		fst_t r;
		r = s;
		r.phase = splr_pkg::PH_HEADER;
		r.fidx = 2'd0;
		r.hdr = 32'd0;
		r.size = 32'd0;
		r.cnt = '0;
		r.lrc = 8'd0;
		r.over = 1'b0;
		return r;
	endfunction

	function automatic td_t finish(td_t t, logic [7:0] id);
		td_t r;
		logic marker;
		r = t;
		marker = (t.s.hdr[23:0] == splr_pkg::END_MARKER);
		r.fin_v = 1'b1;
		if (t.s.hdr[31:24] != id) begin
			r.fin_halt = 1'b1;
			r.fin_st = splr_pkg::ST_WRONG_ID;
			r.s.phase = splr_pkg::PH_HALTED;
		end else if (t.s.over) begin
			r.fin_halt = 1'b1;
			r.fin_st = splr_pkg::ST_OVERSIZE;
			r.s.phase = splr_pkg::PH_HALTED;
		end else if (!t.s.first && marker) begin
			r.fin_halt = 1'b1;
			r.fin_st = splr_pkg::ST_END;
			r.s.phase = splr_pkg::PH_HALTED;
		end else begin
			r.fin_halt = 1'b0;
			r.fin_lrc = t.s.lrc;
			r.fin_first = t.s.first;
			r.fin_mk = t.s.first && marker;
			r.s.first = 1'b0;
			if (r.fin_mk) begin
				r.s.phase = splr_pkg::PH_HALTED;
			end else begin
				r.s = start_pkt(r.s);
			end
		end
		return r;
	endfunction

	// one unstuffed data byte through the packet parser
	function automatic td_t take(fst_t s, logic [7:0] b, logic [7:0] id);
		td_t r;
		logic [31:0] full_size;
		r = '0;
		r.s = s;
		full_size = {b, s.size[23:0]};
		case (s.phase)
			splr_pkg::PH_HEADER: begin
				case (s.fidx)
					2'd0: r.s.hdr[7:0] = b;
					2'd1: r.s.hdr[15:8] = b;
					2'd2: r.s.hdr[23:16] = b;
					default: r.s.hdr[31:24] = b;
				endcase
				r.s.fidx = s.fidx + 2'd1;
				if (s.fidx == 2'd3) begin
					r.s.phase = splr_pkg::PH_SIZE;
				end
			end
			splr_pkg::PH_SIZE: begin
				case (s.fidx)
					2'd0: r.s.size[7:0] = b;
					2'd1: r.s.size[15:8] = b;
					2'd2: r.s.size[23:16] = b;
					default: r.s.size[31:24] = b;
				endcase
				r.s.fidx = s.fidx + 2'd1;
				if (s.fidx == 2'd3) begin
					r.s.phase = splr_pkg::PH_PAYLOAD;
					r.s.over = (full_size > SIZE_LIMIT);
					r.s.cnt = '0;
					r.s.addr = s.hdr[23:0];
					if (full_size == 32'd0) begin
						r = finish(r, id);
					end
				end
			end
			splr_pkg::PH_PAYLOAD: begin
				if (s.cnt < MAX_CNT) begin
					r.pay_v = 1'b1;
					r.pay_byte = b;
					r.pay_addr = s.addr;
					r.s.lrc = s.lrc ^ b;
					r.s.cnt = s.cnt + CW'(1);
					r.s.addr = s.addr + 24'd1;
				end
				r.s.size = s.size - 32'd1;
				if (s.size == 32'd1) begin
					r = finish(r, id);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	fst_t st_q, ns;
	logic esc_q, esc_d;
	td_t t1, t2, fin;
	logic h_v, fv, ack, esc0;
	logic [2:0] h_st;
	logic accept;
	logic [7:0] b;

	assign in_ready = !qstat.full;
	assign accept = in_valid && in_ready;
	assign b = in_data.rx_byte;
	assign halted = (st_q.phase == splr_pkg::PH_HALTED);

	always_comb begin
		ns = st_q;
		esc_d = esc_q;
		t1 = '0;
		t2 = '0;
		h_v = 1'b0;
		h_st = splr_pkg::ST_TIMEOUT;
		case (st_q.phase)
			splr_pkg::PH_AWAIT_FF: begin
				if (in_data.operation == splr_pkg::OP_BYTE && b == splr_pkg::SYNC_BYTE) begin
					ns.phase = splr_pkg::PH_AWAIT_ID;
				end
			end
			splr_pkg::PH_AWAIT_ID: begin
				if (in_data.operation == splr_pkg::OP_BYTE && b == station_id) begin
					esc_d = 1'b0;
					ns = start_pkt(st_q);
				end else begin
					ns.phase = splr_pkg::PH_AWAIT_FF;
				end
			end
			splr_pkg::PH_HEADER, splr_pkg::PH_SIZE, splr_pkg::PH_PAYLOAD: begin
				if (in_data.operation == splr_pkg::OP_TIMEOUT) begin
					h_v = 1'b1;
					h_st = splr_pkg::ST_TIMEOUT;
					ns.phase = splr_pkg::PH_HALTED;
				end else if (esc_q) begin
					if (b == station_id) begin
						h_v = 1'b1;
						h_st = splr_pkg::ST_SYNC_ERR;
						ns.phase = splr_pkg::PH_HALTED;
					end else if (b == splr_pkg::STUFF_BYTE) begin
						esc_d = 1'b0;
						t1 = take(st_q, splr_pkg::SYNC_BYTE, station_id);
						ns = t1.s;
					end else if (b == splr_pkg::SYNC_BYTE) begin
						// double escape: data 0xFF, escape stays pending
						t1 = take(st_q, splr_pkg::SYNC_BYTE, station_id);
						ns = t1.s;
					end else begin
						// lone escape: 0xFF then the byte itself
						esc_d = 1'b0;
						t1 = take(st_q, splr_pkg::SYNC_BYTE, station_id);
						t2 = take(t1.s, b, station_id);
						ns = t2.s;
					end
				end else if (b == splr_pkg::SYNC_BYTE) begin
					esc_d = 1'b1;
				end else begin
					t1 = take(st_q, b, station_id);
					ns = t1.s;
				end
			end
			splr_pkg::PH_HALTED: ;
			default: ns.phase = splr_pkg::PH_HALTED;
		endcase
	end

	// at most one packet end per line byte
	assign fin = t1.fin_v ? t1 : t2;
	assign fv = t1.fin_v || t2.fin_v;
	assign ack = fv && !fin.fin_halt;
	assign esc0 = ack && (fin.fin_lrc == splr_pkg::SYNC_BYTE);

	always_comb begin
		act = '0;
		act.slots[splr_pkg::SL_P0] = t1.pay_v;
		act.slots[splr_pkg::SL_P1] = t2.pay_v;
		act.slots[splr_pkg::SL_HALT] = h_v || (fv && fin.fin_halt);
		act.slots[splr_pkg::SL_FF] = ack;
		act.slots[splr_pkg::SL_ID] = ack;
		act.slots[splr_pkg::SL_LRC] = ack;
		act.slots[splr_pkg::SL_ESC0] = esc0;
		act.slots[splr_pkg::SL_ACKST] = ack;
		// eight results would exceed the per-byte limit of seven: drop the end status
		act.slots[splr_pkg::SL_MARK] = ack && fin.fin_mk && !(t1.pay_v && t2.pay_v && esc0);
		act.p0_byte = t1.pay_byte;
		act.p0_addr = t1.pay_addr;
		act.p1_byte = t2.pay_byte;
		act.p1_addr = t2.pay_addr;
		act.halt_st = h_v ? h_st : fin.fin_st;
		act.lrc = fin.fin_lrc;
		act.id = station_id;
		act.first = fin.fin_first;
	end

	assign push = accept && (act.slots != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: splr_pkg::PH_AWAIT_FF, fidx: 2'd0, hdr: 32'd0, size: 32'd0,
				cnt: '0, addr: 24'd0, lrc: 8'd0, first: 1'b1, over: 1'b0};
			esc_q <= 1'b0;
		end else if (accept) begin
			st_q <= ns;
			esc_q <= esc_d;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/splr_queue.sv
`default_nettype none

module splr_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire splr_pkg::act_t   wdata,
	input  wire logic             pop,
	output splr_pkg::act_t        rdata,
	output splr_pkg::qstat_t      qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	splr_pkg::act_t mem [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CNTW-1:0] cnt_q;

	assign qstat.full = (cnt_q == CNTW'(DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign rdata = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + CNTW'(1);
				2'b01: cnt_q <= cnt_q - CNTW'(1);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/splr_back.sv
`default_nettype none

module splr_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire splr_pkg::act_t   head,
	input  wire splr_pkg::qstat_t qstat,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output splr_pkg::out_t        out_data
);

	logic [splr_pkg::NSLOT-1:0] done_q, rem, low;
	logic load, fin;
	splr_pkg::out_t res, out_q;
	logic out_valid_q;

	assign rem = head.slots & ~done_q;
	assign low = rem & (~rem + splr_pkg::NSLOT'(1));
	assign fin = ((rem & ~low) == '0);
	assign load = !out_valid_q || out_ready;
	assign pop = load && !qstat.empty && fin;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		res = '0;
		res.last = fin;
		if (low[splr_pkg::SL_P0]) begin
			res.kind = splr_pkg::KIND_PAYLOAD;
			res.out_byte = head.p0_byte;
			res.load_address = head.p0_addr;
		end else if (low[splr_pkg::SL_P1]) begin
			res.kind = splr_pkg::KIND_PAYLOAD;
			res.out_byte = head.p1_byte;
			res.load_address = head.p1_addr;
		end else if (low[splr_pkg::SL_HALT]) begin
			res.kind = splr_pkg::KIND_STATUS;
			res.status = head.halt_st;
		end else if (low[splr_pkg::SL_FF]) begin
			res.kind = splr_pkg::KIND_TX;
			res.out_byte = splr_pkg::SYNC_BYTE;
		end else if (low[splr_pkg::SL_ID]) begin
			res.kind = splr_pkg::KIND_TX;
			res.out_byte = head.id;
		end else if (low[splr_pkg::SL_LRC]) begin
			res.kind = splr_pkg::KIND_TX;
			res.out_byte = head.lrc;
		end else if (low[splr_pkg::SL_ESC0]) begin
			res.kind = splr_pkg::KIND_TX;
			res.out_byte = splr_pkg::STUFF_BYTE;
		end else if (low[splr_pkg::SL_ACKST]) begin
			res.kind = splr_pkg::KIND_STATUS;
			res.status = head.first ? splr_pkg::ST_DUMMY : splr_pkg::ST_ACCEPTED;
		end else begin
			res.kind = splr_pkg::KIND_STATUS;
			res.status = splr_pkg::ST_END;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !qstat.empty) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q <= '0;
		end else if (load && !qstat.empty) begin
			out_valid_q <= 1'b1;
			done_q <= fin ? '0 : (done_q | low);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/stuffed_packet_loader_receiver.sv
// A result reaches out_data through the action queue and then the result register.
// Throughput: one line byte per cycle unless the queue is full; results leave at one per cycle
//   unless out_ready stalls; a byte causing up to seven results holds the port until all are out.
// The action queue (QUEUE_DEPTH entries) absorbs bursts; in_ready drops only when it is full.
// Reset (arst_n low, asynchronous): hunt for sync, first-packet flag set, station_id = 1.
`default_nettype none

module stuffed_packet_loader_receiver #(
	parameter int MAX_PACKET_BYTES = 512,   // 1 .. 65536
	parameter int QUEUE_DEPTH = 4           // 2 .. 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	// line byte / timeout channel
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire splr_pkg::in_t   in_data,
	// result channel
	output logic                 out_valid,
	input  wire logic            out_ready,
	output splr_pkg::out_t       out_data,
	// register port
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [2:0]      paddr,
	input  wire logic [31:0]     pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	// station_id register, word 0. User must write it only while the block is idle; unenforced.
	logic [7:0] station_id_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == splr_pkg::REG_STATION_ID);
	assign prdata = (paddr[2] == splr_pkg::REG_STATION_ID) ? {24'd0, station_id_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_id_q <= 8'd1;
		end else if (cfg_wr) begin
			station_id_q <= pwdata[7:0];
		end
	end

	// Front: sync hunt, unstuffing and packet parsing, one line byte per transfer.
	// Each byte becomes at most one action record naming the results it causes.
	splr_pkg::act_t   q_wdata, q_head;
	splr_pkg::qstat_t q_stat;
	logic             q_push, q_pop;
	logic             halted;

	splr_front #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.station_id(station_id_q),
		.qstat     (q_stat),
		.push      (q_push),
		.act       (q_wdata),
		.halted    (halted)
	);

	// Short queue of action records between parser and result sequencer.
	splr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_head),
		.qstat (q_stat)
	);

	// Back: expands each record into results (payload bytes, ack bytes, status),
	// one per cycle unless out_ready stalls, through a registered output stage.
	splr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.qstat    (q_stat),
		.pop      (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("action queue written while full");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted |=> halted)
		else $error("parser left the halted state without reset");

	a_out_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!q_stat.empty))
		else $error("result presented with no queued action");
`endif

endmodule

`default_nettype wire

### test/stuffed_packet_loader_receiver_test.sv
module stuffed_packet_loader_receiver_test;
	import splr_pkg::*;

	localparam int MAX_PAYLOAD = 512;
	localparam int DRAIN_CYCLES = 16;   // action queue depth plus output register, with margin
	localparam logic [2:0] STATION_ADDR = {REG_STATION_ID, 2'b00};

	// one row of the directed script: n < 0 means the deframer model supplies the results
	typedef struct packed {
		in_t        item;
		int         n;
		out_t [3:0] res;
	} rx_step_t;

	// how the last stretch of the run takes the block down
	typedef enum int {
		END_PACKET,
		FOREIGN_ID,
		OVERSIZE,
		LINE_TIMEOUT,
		SYNC_IN_PACKET
	} wrapup_t;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	in_t   in_data;
	logic  out_valid;
	logic  out_ready;
	out_t  out_data;
	logic  psel;
	logic  penable;
	logic  pwrite;
	logic  [2:0] paddr;
	logic  [31:0] pwdata;
	logic  [31:0] prdata;
	logic  pready;

	stuffed_packet_loader_receiver #(
		.MAX_PACKET_BYTES(MAX_PAYLOAD)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int fails;
	int send_idle_pct;
	int stall_pct;

	// results still owed by the block, oldest first
	out_t awaited_results[$];
	// results caused by the line transfer just taken
	out_t step_results[$];

	// unstuffed stream being built, and the line bytes that carry it
	logic [7:0] plain_bytes[$];
	logic [7:0] line_bytes[$];

	// deframer state as this bench tracks it
	logic [7:0]  pred_station;
	phase_t      dp_phase;
	logic        dp_esc;
	logic [1:0]  dp_fidx;
	logic [31:0] dp_hdr;
	logic [31:0] dp_size;
	logic [31:0] dp_pidx;
	logic [7:0]  dp_lrc;
	logic        dp_first;

	function automatic out_t result_of(logic [1:0] kind, logic [7:0] ob, logic [23:0] addr,
			logic [2:0] st, logic fin);
		out_t r;
		r.kind = kind;
		r.out_byte = ob;
		r.load_address = addr;
		r.status = st;
		r.last = fin;
		return r;
	endfunction

	function automatic rx_step_t script_row(logic op, logic [7:0] b, int n, out_t [3:0] res = '0);
		rx_step_t r;
		r.item.operation = op;
		r.item.rx_byte = b;
		r.n = n;
		r.res = res;
		return r;
	endfunction

	function void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
			fails++;
		end
	endfunction

	// ---------------------------------------------------------------- deframer model

	// never more than seven results from one line transfer
	function void post(logic [1:0] kind, logic [7:0] ob, logic [23:0] addr, logic [2:0] st);
		if (step_results.size() < 7)
			step_results.push_back(result_of(kind, ob, addr, st, 1'b0));
	endfunction

	function void halt_on(logic [2:0] st);
		post(KIND_STATUS, 8'h00, 24'h0, st);
		dp_phase = PH_HALTED;
	endfunction

	function void open_packet();
		dp_phase = PH_HEADER;
		dp_fidx = 2'd0;
		dp_hdr = '0;
		dp_size = '0;
		dp_pidx = '0;
		dp_lrc = '0;
	endfunction

	// id check first, then size, then end marker; ack is sync pair plus stuffed LRC
	function void close_packet();
		logic marker;
		marker = (dp_hdr[23:0] == END_MARKER);
		if (dp_hdr[31:24] != pred_station)
			halt_on(ST_WRONG_ID);
		else if (dp_size > MAX_PAYLOAD)
			halt_on(ST_OVERSIZE);
		else if (!dp_first && marker)
			halt_on(ST_END);
		else begin
			post(KIND_TX, SYNC_BYTE, 24'h0, '0);
			post(KIND_TX, pred_station, 24'h0, '0);
			post(KIND_TX, dp_lrc, 24'h0, '0);
			if (dp_lrc == SYNC_BYTE)
				post(KIND_TX, STUFF_BYTE, 24'h0, '0);
			if (dp_first) begin
				// dummy packet: acked whatever its address
				dp_first = 1'b0;
				post(KIND_STATUS, 8'h00, 24'h0, ST_DUMMY);
				if (marker)
					halt_on(ST_END);
				else
					open_packet();
			end else begin
				post(KIND_STATUS, 8'h00, 24'h0, ST_ACCEPTED);
				open_packet();
			end
		end
	endfunction

	// one unstuffed byte into header, size or payload
	function void absorb(logic [7:0] b);
		case (dp_phase)
			PH_HEADER: begin
				dp_hdr = dp_hdr | (32'(b) << (8 * dp_fidx));
				dp_fidx = dp_fidx + 2'd1;
				if (dp_fidx == 2'd0)
					dp_phase = PH_SIZE;
			end
			PH_SIZE: begin
				dp_size = dp_size | (32'(b) << (8 * dp_fidx));
				dp_fidx = dp_fidx + 2'd1;
				if (dp_fidx == 2'd0) begin
					dp_phase = PH_PAYLOAD;
					if (dp_size == 0)
						close_packet();
				end
			end
			PH_PAYLOAD: begin
				if (dp_pidx < MAX_PAYLOAD) begin
					post(KIND_PAYLOAD, b, 24'(dp_hdr + dp_pidx), '0);
					dp_lrc = dp_lrc ^ b;
				end
				dp_pidx = dp_pidx + 1;
				if (dp_pidx == dp_size)
					close_packet();
			end
			default: ;
		endcase
	endfunction

	function void deframe_step(in_t it);
		step_results.delete();
		if (dp_phase == PH_HALTED) begin
			// dead until reset
		end else if (dp_phase == PH_AWAIT_FF) begin
			if (it.operation == OP_BYTE && it.rx_byte == SYNC_BYTE)
				dp_phase = PH_AWAIT_ID;
		end else if (dp_phase == PH_AWAIT_ID) begin
			if (it.operation == OP_BYTE && it.rx_byte == pred_station) begin
				dp_esc = 1'b0;
				open_packet();
			end else
				dp_phase = PH_AWAIT_FF;
		end else if (it.operation == OP_TIMEOUT)
			halt_on(ST_TIMEOUT);
		else if (dp_esc) begin
			// station id wins over the stuff byte
			if (it.rx_byte == pred_station)
				halt_on(ST_SYNC_ERR);
			else if (it.rx_byte == STUFF_BYTE) begin
				dp_esc = 1'b0;
				absorb(SYNC_BYTE);
			end else if (it.rx_byte == SYNC_BYTE)
				absorb(SYNC_BYTE);          // escape stays pending
			else begin
				dp_esc = 1'b0;
				absorb(SYNC_BYTE);
				if (dp_phase != PH_HALTED)
					absorb(it.rx_byte);
			end
		end else if (it.rx_byte == SYNC_BYTE)
			dp_esc = 1'b1;
		else
			absorb(it.rx_byte);
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last = 1'b1;
	endfunction

	function void queue_predicted();
		foreach (step_results[j])
			awaited_results.push_back(step_results[j]);
	endfunction

	// ---------------------------------------------------------------- stream building

	function logic [23:0] random_addr();
		logic [23:0] a;
		a = 24'($urandom);
		if (a == END_MARKER)
			a = 24'h0;
		return a;
	endfunction

	// header word id<<24|addr and size word, both little endian, then payload
	function void add_packet(logic [23:0] addr, logic [7:0] pid, int unsigned size);
		int unsigned pick;
		logic [7:0] d;
		plain_bytes.push_back(addr[7:0]);
		plain_bytes.push_back(addr[15:8]);
		plain_bytes.push_back(addr[23:16]);
		plain_bytes.push_back(pid);
		for (int k = 0; k < 4; k++)
			plain_bytes.push_back(8'(size >> (8 * k)));
		// lean on the bytes the unstuffer cares about
		repeat (size) begin
			pick = $urandom_range(99, 0);
			if (pick < 25)
				d = SYNC_BYTE;
			else if (pick < 35)
				d = STUFF_BYTE;
			else if (pick < 45)
				d = pred_station;
			else
				d = 8'($urandom);
			plain_bytes.push_back(d);
		end
	endfunction

	// Stuff the plain stream; each data 0xFF is sent as FF 00, as FF x when the next
	// data byte x can stand alone, or as FF FF (second one stays pending) when the
	// next data byte is 0xFF too and the id is not 0xFF. Spans packet boundaries.
	function void stuff_line();
		int i;
		bit owed;
		int unsigned pick;
		logic [7:0] d;
		i = 0;
		owed = 1'b0;
		while (i < plain_bytes.size()) begin
			d = plain_bytes[i];
			if (!owed) begin
				line_bytes.push_back(d);
				owed = (d == SYNC_BYTE);
				i++;
			end else begin
				pick = $urandom_range(2, 0);
				if (pick == 1 && d == SYNC_BYTE && pred_station != SYNC_BYTE) begin
					line_bytes.push_back(SYNC_BYTE);
					i++;
				end else if (pick == 2 && d != STUFF_BYTE && d != SYNC_BYTE &&
						d != pred_station) begin
					line_bytes.push_back(d);
					owed = 1'b0;
					i++;
				end else begin
					line_bytes.push_back(STUFF_BYTE);
					owed = 1'b0;
				end
			end
		end
		if (owed)
			line_bytes.push_back(STUFF_BYTE);
		plain_bytes.delete();
	endfunction

	// ---------------------------------------------------------------- drivers

	// Sender: optional idle cycles, then hold valid until the transfer edge.
	task accept_item(input in_t it);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		deframe_step(it);
	endtask

	task feed(input in_t it);
		accept_item(it);
		queue_predicted();
	endtask

	task send_line();
		in_t it;
		while (line_bytes.size() > 0) begin
			it.operation = OP_BYTE;
			it.rx_byte = line_bytes.pop_front();
			feed(it);
		end
	endtask

	// sender holds off until every owed result is out, then lets the queue empty
	task drain();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// APB write of station_id, then read it back
	task program_station(input logic [7:0] id);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= STATION_ADDR;
		pwdata <= {24'h0, id};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pred_station = id;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("station_id readback", {24'h0, id}, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// receiver stalls at the rate of the current phase
	always @(posedge clk)
		out_ready <= ($urandom_range(99, 0) >= stall_pct);

	// result port: every transfer must match the oldest owed result
	always @(posedge clk) begin : result_port
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %p", $time, out_data);
				fails++;
			end else begin
				want = awaited_results.pop_front();
				check_field("kind", want.kind, out_data.kind);
				check_field("out_byte", want.out_byte, out_data.out_byte);
				check_field("load_address", want.load_address, out_data.load_address);
				check_field("status", want.status, out_data.status);
				check_field("last", want.last, out_data.last);
			end
		end
	end

	// hard stop in case the block hangs
	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		rx_step_t script[26];
		int send_pcts[4];
		int stall_pcts[4];
		logic [7:0] ids[4];
		in_t it;
		wrapup_t how;
		int unsigned cut;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fails = 0;
		send_idle_pct = 0;
		stall_pct = 0;

		// reset view of the deframer
		pred_station = 8'h01;
		dp_phase = PH_AWAIT_FF;
		dp_esc = 1'b0;
		dp_fidx = 2'd0;
		dp_hdr = '0;
		dp_size = '0;
		dp_pidx = '0;
		dp_lrc = '0;
		dp_first = 1'b1;

		script = '{
			// sync hunt with id 1: timeouts and non-id bytes after FF fall back
			script_row(OP_TIMEOUT, 8'h5A, 0),
			script_row(OP_BYTE, SYNC_BYTE, 0),
			script_row(OP_TIMEOUT, 8'h00, 0),
			script_row(OP_BYTE, SYNC_BYTE, 0),
			script_row(OP_BYTE, SYNC_BYTE, 0),
			script_row(OP_BYTE, SYNC_BYTE, 0),
			script_row(OP_BYTE, 8'h01, 0),
			// dummy packet, header 0x017F8000, zero size: acked right after the size word
			script_row(OP_BYTE, 8'h00, 0),
			script_row(OP_BYTE, 8'h80, 0),
			script_row(OP_BYTE, 8'h7F, 0),
			script_row(OP_BYTE, 8'h01, 0),
			script_row(OP_BYTE, 8'h00, 0),
			script_row(OP_BYTE, 8'h00, 0),
			script_row(OP_BYTE, 8'h00, 0),
			script_row(OP_BYTE, 8'h00, 4, {
				result_of(KIND_STATUS, 8'h00, 24'h0, ST_DUMMY, 1'b1),
				result_of(KIND_TX, 8'h00, 24'h0, '0, 1'b0),
				result_of(KIND_TX, 8'h01, 24'h0, '0, 1'b0),
				result_of(KIND_TX, SYNC_BYTE, 24'h0, '0, 1'b0)}),
			// address 0xFFFFFF built from double escapes, id 1
			script_row(OP_BYTE, SYNC_BYTE, -1),
			script_row(OP_BYTE, SYNC_BYTE, -1),
			script_row(OP_BYTE, SYNC_BYTE, -1),
			script_row(OP_BYTE, STUFF_BYTE, -1),
			script_row(OP_BYTE, 8'h01, -1),
			script_row(OP_BYTE, 8'h02, -1),
			script_row(OP_BYTE, 8'h00, -1),
			script_row(OP_BYTE, 8'h00, -1),
			script_row(OP_BYTE, 8'h00, -1),
			// FF 80 is two payload bytes; address wraps to zero, packet closes at once
			script_row(OP_BYTE, SYNC_BYTE, -1),
			script_row(OP_BYTE, 8'h80, -1)
		};

		send_pcts = '{0, 59, 0, 11};
		stall_pcts = '{0, 0, 59, 11};
		ids = '{8'hFF, 8'($urandom_range(254, 2)), 8'h01, 8'($urandom_range(255, 1))};

		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		foreach (script[k]) begin
			accept_item(script[k].item);
			if (script[k].n < 0)
				queue_predicted();
			else
				for (int j = 0; j < script[k].n; j++)
					awaited_results.push_back(script[k].res[j]);
		end
		drain();

		// random packets; new station id between phases, at packet boundaries only
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_pcts[p];
			stall_pct = stall_pcts[p];
			program_station(ids[p]);
			while (plain_bytes.size() < 56) begin
				cut = $urandom_range(99, 0);
				if (cut < 12)
					add_packet(random_addr(), pred_station, 0);
				else if (cut < 90)
					add_packet(random_addr(), pred_station, $urandom_range(8, 1));
				else
					add_packet(random_addr(), pred_station, $urandom_range(40, 9));
			end
			stuff_line();
			send_line();
			drain();
		end

		// take the block down one way, then show that it stays quiet
		how = wrapup_t'($urandom_range(SYNC_IN_PACKET, END_PACKET));
		case (how)
			END_PACKET:
				add_packet(END_MARKER, pred_station, $urandom_range(6, 0));
			FOREIGN_ID:
				add_packet(random_addr(), pred_station ^ 8'($urandom_range(255, 1)),
					$urandom_range(6, 0));
			OVERSIZE:
				add_packet(random_addr(), pred_station, MAX_PAYLOAD + 1);
			default:
				add_packet(random_addr(), pred_station, $urandom_range(6, 0));
		endcase
		stuff_line();
		if (how == LINE_TIMEOUT || how == SYNC_IN_PACKET) begin
			// break off anywhere in header, size or payload
			cut = $urandom_range(line_bytes.size() - 1, 0);
			while (line_bytes.size() > cut)
				void'(line_bytes.pop_back());
			if (how == LINE_TIMEOUT) begin
				send_line();
				it.operation = OP_TIMEOUT;
				it.rx_byte = 8'($urandom);
				feed(it);
			end else begin
				line_bytes.push_back(SYNC_BYTE);
				line_bytes.push_back(pred_station);
				send_line();
			end
		end else
			send_line();
		repeat (6) begin
			it.operation = 1'($urandom);
			it.rx_byte = 8'($urandom);
			feed(it);
		end
		drain();

		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
